>>> rtl/prpi_pkg.sv
package prpi_pkg;

   localparam int VERTEX_W  = 6;
   localparam int MAX_VERTS = 64;
   localparam int COUNT_W   = 7;
   localparam int RANK_W    = 25;   // Q0.24 plus one integer bit for a start rank of 1.0
   localparam int SUM_W     = 31;
   localparam int PROD_W    = 47;
   localparam int ITER_W    = 10;
   localparam int DAMP_W    = 16;
   localparam int THR_W     = 24;
   localparam int CSR_W     = 24;

   localparam logic [RANK_W-1:0] RANK_ONE = 25'h1000000;
   localparam logic [RANK_W-1:0] RANK_SAT = 25'h0FFFFFF;

   typedef enum logic [1:0] {
      CMD_ADD_EDGE = 2'd0,
      CMD_CLEAR    = 2'd1,
      CMD_RUN      = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_VERTEX_COUNT = 3'd0,
      CSR_MAX_ITER     = 3'd1,
      CSR_DAMPING      = 3'd2,
      CSR_PERSONAL     = 3'd3,
      CSR_ROOT         = 3'd4,
      CSR_THRESHOLD    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_TELEPORT = 2'd0,
      DIV_INIT     = 2'd1,
      DIV_CONTRIB  = 2'd2
   } div_op_type;

   typedef struct packed {
      logic                edge_rd;
      logic                edge_wr;
      logic                clear;
      logic                run_start;
      logic                div_start;
      div_op_type          div_op;
      logic                fill;
      logic                div_rd;
      logic                row_rd;
      logic                sum_rd;
      logic                mul;
      logic                fin;
      logic                swap;
      logic                out_rd;
      logic                out_load;
      logic [VERTEX_W-1:0] u;
      logic [VERTEX_W-1:0] v;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                div_done;
      logic                conv_hit;
      logic [VERTEX_W-1:0] n_last;
      logic [ITER_W-1:0]   max_iter;
   } dp_status_type;

   // zero acts as one, anything above the vertex limit is clipped
   function automatic logic [COUNT_W-1:0] active_n(input logic [COUNT_W-1:0] vc);
      logic [COUNT_W-1:0] n;
      n = vc;
      if (vc == '0) n = COUNT_W'(1);
      if (vc > COUNT_W'(MAX_VERTS)) n = COUNT_W'(MAX_VERTS);
      return n;
   endfunction

endpackage

>>> rtl/pagerank_power_iteration.sv
// Add edge: row read, then row and out-degree write. Clear: done in the idle state.
// Run: the serial divider makes the teleport share and the start rank, then each step
// divides every vertex's contribution and sums each row one candidate neighbour per cycle.
// Results then leave one vertex at a time; a stall on the output side holds the current one.
// Reset (synchronous) empties the graph and restores default registers; no clearing pass.
module pagerank_power_iteration (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_edge_source,
   input  logic [5:0]  req_edge_target,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_vertex,
   output logic [23:0] rsp_rank,
   output logic        rsp_converged,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import prpi_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   prpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   prpi_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_edge_source (req_edge_source),
      .req_edge_target (req_edge_target),
      .rsp_vertex      (rsp_vertex),
      .rsp_rank        (rsp_rank),
      .rsp_converged   (rsp_converged),
      .rsp_last        (rsp_last)
   );

   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while results pending");

   a_more_after_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> req_stall)
      else $error("block went idle before last result");

   a_clear_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == CMD_CLEAR) |=> !req_stall && !rsp_valid)
      else $error("clear did not complete in one cycle");

endmodule

>>> rtl/prpi_div.sv
module prpi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [24:0] dividend,
   input  logic [6:0]  divisor,
   output logic        done,
   output logic [24:0] quotient
);
   import prpi_pkg::*;

   logic [RANK_W-1:0] quo_ff, quo_in;
   logic [7:0]        rem_ff, rem_in;
   logic [6:0]        dsr_ff;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [7:0]        rem_shift;
   logic              ge;

   assign rem_shift = {rem_ff[6:0], quo_ff[RANK_W-1]};
   assign ge        = rem_shift >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[RANK_W-2:0], ge};
         rem_in = ge ? rem_shift - {1'b0, dsr_ff} : rem_shift;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(RANK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) dsr_ff <= divisor;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/prpi_datapath.sv
module prpi_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  prpi_pkg::ctrl_cmd_type cmd,
   output prpi_pkg::dp_status_type status,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [23:0]            csr_wdata,
   input  logic [5:0]             req_edge_source,
   input  logic [5:0]             req_edge_target,
   output logic [5:0]             rsp_vertex,
   output logic [23:0]            rsp_rank,
   output logic                   rsp_converged,
   output logic                   rsp_last
);
   import prpi_pkg::*;

   // configuration
   logic [COUNT_W-1:0]  vcount_ff;
   logic [ITER_W-1:0]   max_iter_ff;
   logic [DAMP_W-1:0]   damp_ff;
   logic                personal_ff;
   logic [VERTEX_W-1:0] root_ff;
   logic [THR_W-1:0]    thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff   <= 7'd64;
         max_iter_ff <= 10'd100;
         damp_ff     <= 16'd55706;
         personal_ff <= 1'b0;
         root_ff     <= '0;
         thr_ff      <= 24'd16777;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_MAX_ITER:     max_iter_ff <= csr_wdata[ITER_W-1:0];
            CSR_DAMPING:      damp_ff     <= csr_wdata[DAMP_W-1:0];
            CSR_PERSONAL:     personal_ff <= csr_wdata[0];
            CSR_ROOT:         root_ff     <= csr_wdata[VERTEX_W-1:0];
            CSR_THRESHOLD:    thr_ff      <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   logic [COUNT_W-1:0]  n;
   logic [VERTEX_W-1:0] n_last;
   assign n      = active_n(vcount_ff);
   assign n_last = VERTEX_W'(n - COUNT_W'(1));

   // incoming-edge rows and out-degrees, with row valid bits cleared at once
   logic [MAX_VERTS-1:0] row_mem [MAX_VERTS];
   logic [COUNT_W-1:0]   deg_mem [MAX_VERTS];
   logic [MAX_VERTS-1:0] row_vld_ff;
   logic [MAX_VERTS-1:0] deg_vld_ff;
   logic [MAX_VERTS-1:0] row_rd_ff;
   logic [COUNT_W-1:0]   deg_rd_ff;
   logic                 row_ok_ff, deg_ok_ff;
   logic [MAX_VERTS-1:0] row_q;
   logic [COUNT_W-1:0]   deg_q;
   logic [VERTEX_W-1:0]  row_addr, deg_addr;
   logic [VERTEX_W-1:0]  src_ff, dst_ff;
   logic                 edge_new;

   assign row_addr = cmd.edge_rd ? req_edge_target : cmd.u;
   assign deg_addr = cmd.edge_rd ? req_edge_source : cmd.v;
   assign row_q    = row_ok_ff ? row_rd_ff : '0;
   assign deg_q    = deg_ok_ff ? deg_rd_ff : '0;
   assign edge_new = (src_ff != dst_ff) && !row_q[src_ff];

   always_ff @(posedge clock) begin
      if (cmd.edge_rd || cmd.row_rd) begin
         row_rd_ff <= row_mem[row_addr];
         row_ok_ff <= row_vld_ff[row_addr];
      end
      if (cmd.edge_rd || cmd.div_rd) begin
         deg_rd_ff <= deg_mem[deg_addr];
         deg_ok_ff <= deg_vld_ff[deg_addr];
      end
      if (cmd.edge_rd) begin
         src_ff <= req_edge_source;
         dst_ff <= req_edge_target;
      end
      if (cmd.edge_wr && edge_new) begin
         row_mem[dst_ff] <= row_q | (MAX_VERTS'(1) << src_ff);
         deg_mem[src_ff] <= deg_q + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         row_vld_ff <= '0;
         deg_vld_ff <= '0;
      end else if (cmd.edge_wr && edge_new) begin
         row_vld_ff[dst_ff] <= 1'b1;
         deg_vld_ff[src_ff] <= 1'b1;
      end
   end

   // rank ping-pong banks: bank_ff selects the current half
   logic [RANK_W-1:0] rank_mem [2*MAX_VERTS];
   logic [RANK_W-1:0] rank_q_ff;
   logic              bank_ff;
   logic [VERTEX_W:0] rank_raddr, rank_waddr;
   logic [RANK_W-1:0] rank_wdata;
   logic [RANK_W-1:0] init_ff, uni_tp_ff, nr;

   assign rank_raddr = cmd.div_rd ? {bank_ff, cmd.v} : {bank_ff, cmd.u};
   assign rank_waddr = cmd.fill ? {bank_ff, cmd.u} : {~bank_ff, cmd.u};
   assign rank_wdata = cmd.fill ? init_ff : nr;

   always_ff @(posedge clock) begin
      if (cmd.div_rd || cmd.row_rd || cmd.out_rd) rank_q_ff <= rank_mem[rank_raddr];
      if (cmd.fill || cmd.fin) rank_mem[rank_waddr] <= rank_wdata;
   end

   // shared divider: teleport share, start rank, per-vertex contribution
   logic [RANK_W-1:0] tp_root;
   logic [RANK_W-1:0] div_dividend;
   logic [6:0]        div_divisor;
   logic              div_done;
   logic [RANK_W-1:0] div_quo;
   div_op_type        div_op_ff;

   assign tp_root = {17'h10000 - {1'b0, damp_ff}, 8'h00};

   always_comb begin
      case (cmd.div_op)
         DIV_TELEPORT: begin
            div_dividend = tp_root;
            div_divisor  = n;
         end
         DIV_INIT: begin
            div_dividend = RANK_ONE;
            div_divisor  = n;
         end
         DIV_CONTRIB: begin
            div_dividend = rank_q_ff;
            div_divisor  = deg_q;
         end
         default: begin
            div_dividend = rank_q_ff;
            div_divisor  = deg_q;
         end
      endcase
   end

   prpi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   logic [RANK_W-1:0] contrib_mem [MAX_VERTS];
   logic [RANK_W-1:0] contrib_q_ff;
   logic              sel_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_start) div_op_ff <= cmd.div_op;
      if (div_done) begin
         case (div_op_ff)
            DIV_TELEPORT: uni_tp_ff <= div_quo;
            DIV_INIT:     init_ff   <= div_quo;
            DIV_CONTRIB:  contrib_mem[cmd.v] <= (deg_q == '0) ? '0 : div_quo;
            default: ;
         endcase
      end
      if (cmd.sum_rd) contrib_q_ff <= contrib_mem[cmd.v];
   end

   // neighbour sum, damping, teleport, change
   logic [SUM_W-1:0]  sum_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  change_ff;
   logic              conv_ff;
   logic [RANK_W-1:0] tp_sel, diff;
   logic [SUM_W:0]    nr_sum;

   always_comb begin
      if (personal_ff) tp_sel = (cmd.u == root_ff) ? tp_root : '0;
      else             tp_sel = uni_tp_ff;
      nr_sum = {1'b0, prod_ff[PROD_W-1:DAMP_W]} + (SUM_W+1)'(tp_sel);
      nr     = (nr_sum > (SUM_W+1)'(RANK_SAT)) ? RANK_SAT : nr_sum[RANK_W-1:0];
      diff   = (rank_q_ff > nr) ? rank_q_ff - nr : nr - rank_q_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.row_rd) sum_ff <= '0;
      else if (sel_ff) sum_ff <= sum_ff + SUM_W'(contrib_q_ff);
      if (cmd.mul) prod_ff <= PROD_W'(damp_ff) * PROD_W'(sum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff    <= 1'b0;
         bank_ff   <= 1'b0;
         conv_ff   <= 1'b0;
         change_ff <= '0;
      end else begin
         sel_ff <= cmd.sum_rd && row_q[cmd.v];
         if (cmd.run_start) begin
            conv_ff   <= 1'b0;
            change_ff <= '0;
         end else if (cmd.swap) begin
            bank_ff   <= ~bank_ff;
            conv_ff   <= status.conv_hit;
            change_ff <= '0;
         end else if (cmd.fin) begin
            change_ff <= change_ff + SUM_W'(diff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_vertex    <= cmd.u;
         rsp_rank      <= rank_q_ff[23:0];
         rsp_converged <= conv_ff;
         rsp_last      <= (cmd.u == n_last);
      end
   end

   assign status.div_done = div_done;
   assign status.conv_hit = change_ff < SUM_W'(thr_ff);
   assign status.n_last   = n_last;
   assign status.max_iter = max_iter_ff;

endmodule

>>> rtl/prpi_ctrl.sv
module prpi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_cmd,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  prpi_pkg::dp_status_type status,
   output prpi_pkg::ctrl_cmd_type  cmd
);
   import prpi_pkg::*;

   typedef enum logic [16:0] {
      ST_IDLE      = 17'h00001,
      ST_EDGE_WR   = 17'h00002,
      ST_TP_WAIT   = 17'h00004,
      ST_INIT_WAIT = 17'h00008,
      ST_FILL      = 17'h00010,
      ST_DIV_RD    = 17'h00020,
      ST_DIV_GO    = 17'h00040,
      ST_DIV_WAIT  = 17'h00080,
      ST_ROW_RD    = 17'h00100,
      ST_SUM_LOOP  = 17'h00200,
      ST_SUM_TAIL  = 17'h00400,
      ST_MUL       = 17'h00800,
      ST_FIN       = 17'h01000,
      ST_CHECK     = 17'h02000,
      ST_OUT_RD    = 17'h04000,
      ST_OUT_LOAD  = 17'h08000,
      ST_OUT_WAIT  = 17'h10000
   } state_type;

   state_type           state_ff, state_in;
   logic [VERTEX_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [ITER_W-1:0]   step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.div_op = DIV_CONTRIB;
      cmd.u    = u_ff;
      cmd.v    = v_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_ADD_EDGE: begin
                     cmd.edge_rd = 1'b1;
                     state_in    = ST_EDGE_WR;
                  end
                  CMD_CLEAR: cmd.clear = 1'b1;
                  CMD_RUN: begin
                     cmd.run_start = 1'b1;
                     cmd.div_start = 1'b1;
                     cmd.div_op    = DIV_TELEPORT;
                     state_in      = ST_TP_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_EDGE_WR: begin
            cmd.edge_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_TP_WAIT: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_INIT;
               state_in      = ST_INIT_WAIT;
            end
         end
         ST_INIT_WAIT: begin
            if (status.div_done) begin
               u_in     = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (u_ff == status.n_last) begin
               u_in    = '0;
               v_in    = '0;
               step_in = '0;
               state_in = (status.max_iter == '0) ? ST_OUT_RD : ST_DIV_RD;
            end else begin
               u_in = u_ff + VERTEX_W'(1);
            end
         end
         ST_DIV_RD: begin
            cmd.div_rd = 1'b1;
            state_in   = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               if (v_ff == status.n_last) begin
                  u_in     = '0;
                  state_in = ST_ROW_RD;
               end else begin
                  v_in     = v_ff + VERTEX_W'(1);
                  state_in = ST_DIV_RD;
               end
            end
         end
         ST_ROW_RD: begin
            cmd.row_rd = 1'b1;
            v_in       = '0;
            state_in   = ST_SUM_LOOP;
         end
         ST_SUM_LOOP: begin
            cmd.sum_rd = 1'b1;
            if (v_ff == status.n_last) state_in = ST_SUM_TAIL;
            else v_in = v_ff + VERTEX_W'(1);
         end
         ST_SUM_TAIL: state_in = ST_MUL;
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            if (u_ff == status.n_last) begin
               state_in = ST_CHECK;
            end else begin
               u_in     = u_ff + VERTEX_W'(1);
               state_in = ST_ROW_RD;
            end
         end
         ST_CHECK: begin
            cmd.swap = 1'b1;
            u_in     = '0;
            v_in     = '0;
            if (status.conv_hit ||
                ({1'b0, step_ff} + 11'd1) == {1'b0, status.max_iter}) begin
               state_in = ST_OUT_RD;
            end else begin
               step_in  = step_ff + ITER_W'(1);
               state_in = ST_DIV_RD;
            end
         end
         ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               if (u_ff == status.n_last) begin
                  state_in = ST_IDLE;
               end else begin
                  u_in     = u_ff + VERTEX_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         u_ff     <= '0;
         v_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         u_ff     <= u_in;
         v_ff     <= v_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT_WAIT);

endmodule

>>> bench/pagerank_power_iteration_tb.sv
`timescale 1ns / 1ps

module pagerank_power_iteration_tb;
   import prpi_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [5:0]  vertex;
      logic [23:0] rank;
      logic        converged;
      logic        last;
   } rank_entry_type;

   class rank_scoreboard;
      logic [6:0]  vertex_count;
      logic [9:0]  max_iterations;
      logic [15:0] damping;
      logic        personalized;
      logic [5:0]  root;
      logic [23:0] threshold;
      logic [63:0] incoming[64];
      logic [6:0]  out_deg[64];
      rank_entry_type pending_ranks[$];
      int          errors;

      function new();
         vertex_count   = 7'd64;
         max_iterations = 10'd100;
         damping        = 16'd55706;
         personalized   = 1'b0;
         root           = 6'd0;
         threshold      = 24'd16777;
         errors         = 0;
         foreach (incoming[i]) begin
            incoming[i] = '0;
            out_deg[i]  = '0;
         end
      endfunction

      function void set_reg(csr_index_type idx, logic [23:0] value);
         case (idx)
            CSR_VERTEX_COUNT: vertex_count   = value[6:0];
            CSR_MAX_ITER:     max_iterations = value[9:0];
            CSR_DAMPING:      damping        = value[15:0];
            CSR_PERSONAL:     personalized   = value[0];
            CSR_ROOT:         root           = value[5:0];
            CSR_THRESHOLD:    threshold      = value;
            default: ;
         endcase
      endfunction

      function void compute_ranks();
         longint unsigned cur[64], nxt[64];
         longint unsigned n, sum, nr, tp, change, uni_tp, root_tp, d;
         bit conv;
         rank_entry_type e;
         n = vertex_count;
         if (n == 0) n = 1;
         if (n > 64) n = 64;
         d = damping;
         uni_tp  = ((65536 - d) << 24) / (n << 16);
         root_tp = ((65536 - d) << 24) >> 16;
         conv = 0;
         for (int u = 0; u < n; u++) cur[u] = (64'd1 << 24) / n;
         for (int s = 0; s < max_iterations; s++) begin
            change = 0;
            for (int u = 0; u < n; u++) begin
               sum = 0;
               for (int v = 0; v < n; v++)
                  if (incoming[u][v] && out_deg[v] != 0) sum += cur[v] / out_deg[v];
               nr = (d * sum) >> 16;
               if (personalized) tp = (u == root) ? root_tp : 0;
               else tp = uni_tp;
               nr += tp;
               if (nr > 64'hFFFFFF) nr = 64'hFFFFFF;
               nxt[u] = nr;
               change += (cur[u] > nr) ? cur[u] - nr : nr - cur[u];
            end
            for (int u = 0; u < n; u++) cur[u] = nxt[u];
            if (change < threshold) begin
               conv = 1;
               break;
            end
         end
         for (int u = 0; u < n; u++) begin
            e.vertex    = u[5:0];
            e.rank      = cur[u][23:0];
            e.converged = conv;
            e.last      = (u == n - 1);
            pending_ranks.push_back(e);
         end
      endfunction

      function void note_item(logic [1:0] cmd, logic [5:0] src, logic [5:0] dst);
         case (cmd)
            CMD_ADD_EDGE: begin
               if (src != dst && !incoming[dst][src]) begin
                  incoming[dst][src] = 1'b1;
                  out_deg[src] = out_deg[src] + 7'd1;
               end
            end
            CMD_CLEAR: begin
               foreach (incoming[i]) begin
                  incoming[i] = '0;
                  out_deg[i]  = '0;
               end
            end
            CMD_RUN: compute_ranks();
            default: ;
         endcase
      endfunction

      function void check_result(logic [5:0] vertex, logic [23:0] rank,
                                 logic converged, logic last);
         rank_entry_type e;
         if (pending_ranks.size() == 0) begin
            $error("unexpected rank result for vertex %0d", vertex);
            errors++;
            return;
         end
         e = pending_ranks.pop_front();
         if (vertex !== e.vertex) begin
            $error("vertex: expected %0d, got %0d", e.vertex, vertex);
            errors++;
         end
         if (rank !== e.rank) begin
            $error("rank: expected %h, got %h", e.rank, rank);
            errors++;
         end
         if (converged !== e.converged) begin
            $error("converged: expected %0b, got %0b", e.converged, converged);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [5:0]  req_edge_source;
   logic [5:0]  req_edge_target;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_vertex;
   logic [23:0] rsp_rank;
   logic        rsp_converged;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;

   rank_scoreboard ranks = new();
   int  stall_left;
   int  hold_left;
   bit  hold_request;
   bit  quiet_out;
   int  active_n_cfg;

   pagerank_power_iteration dut (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #(12 * 4_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         ranks.note_item(req_cmd, req_edge_source, req_edge_target);
      if (!reset && rsp_valid && !rsp_stall)
         ranks.check_result(rsp_vertex, rsp_rank, rsp_converged, rsp_last);
   end

   // output side: short random stalls, rare long ones, one requested long hold
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (!quiet_out && $urandom_range(0, 3) == 0)
               stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 3);
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [23:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      ranks.set_reg(idx, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_config(int n, int iters, int damp, int pers, int rt, int thr);
      write_reg(CSR_VERTEX_COUNT, 24'(n));
      write_reg(CSR_MAX_ITER, 24'(iters));
      write_reg(CSR_DAMPING, 24'(damp));
      write_reg(CSR_PERSONAL, 24'(pers));
      write_reg(CSR_ROOT, 24'(rt));
      write_reg(CSR_THRESHOLD, 24'(thr));
      active_n_cfg = (n == 0) ? 1 : (n > 64 ? 64 : n);
   endtask

   // called at a falling edge; returns at a falling edge after acceptance
   task automatic send_item(logic [1:0] cmd, logic [5:0] src, logic [5:0] dst, bit gaps);
      int gap;
      gap = 0;
      if (gaps && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 10) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      req_valid = 1'b0;
      repeat (gap) @(negedge clock);
      req_valid       = 1'b1;
      req_cmd         = cmd;
      req_edge_source = src;
      req_edge_target = dst;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // drop valid at once so the last item is not taken a second time
   task automatic wait_idle();
      req_valid = 1'b0;
      @(negedge clock);
      while (ranks.pending_ranks.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_phase(int items, bit big);
      int n, r;
      logic [5:0] s, t;
      n = big ? 64 : $urandom_range(1, 10);
      set_config(($urandom_range(0, 9) == 0) ? 0 : n,
                 big ? $urandom_range(0, 2) : $urandom_range(0, 20),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(40000, 62000),
                 $urandom_range(0, 1),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                             : $urandom_range(0, 40000));
      quiet_out = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            if ($urandom_range(0, 7) == 0) begin
               s = 6'($urandom);
               t = 6'($urandom);
            end else begin
               s = 6'($urandom_range(0, active_n_cfg - 1));
               t = 6'($urandom_range(0, active_n_cfg - 1));
            end
            send_item(CMD_ADD_EDGE, s, t, 1);
         end else if (r < 88) send_item(CMD_CLEAR, 6'($urandom), 6'($urandom), 1);
         else if (r < 91) send_item(CMD_UNUSED, 6'($urandom), 6'($urandom), 1);
         else if (!big || i == items - 1) send_item(CMD_RUN, 6'($urandom), 6'($urandom), 1);
      end
      if (!big) send_item(CMD_RUN, 6'($urandom), 6'($urandom), 1);
      wait_idle();
      quiet_out = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_ADD_EDGE;
      req_edge_source = '0;
      req_edge_target = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_VERTEX_COUNT;
      csr_wdata = '0;
      hold_request = 1'b0;
      quiet_out = 1'b0;
      active_n_cfg = 64;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: small ring, self-loop, duplicate, edges past N, unknown command
      set_config(4, 0, 55706, 0, 0, 16777);
      send_item(CMD_ADD_EDGE, 6'd0, 6'd1, 0);
      send_item(CMD_ADD_EDGE, 6'd1, 6'd2, 0);
      send_item(CMD_ADD_EDGE, 6'd2, 6'd0, 0);
      send_item(CMD_ADD_EDGE, 6'd2, 6'd0, 0);
      send_item(CMD_ADD_EDGE, 6'd3, 6'd3, 0);
      send_item(CMD_ADD_EDGE, 6'd3, 6'd63, 0);
      send_item(CMD_ADD_EDGE, 6'd63, 6'd1, 0);
      send_item(CMD_ADD_EDGE, 6'd3, 6'd0, 0);
      send_item(CMD_UNUSED, 6'd63, 6'd63, 0);
      send_item(CMD_RUN, 6'd0, 6'd0, 0);
      wait_idle();
      set_config(4, 1023, 65535, 0, 0, 0);
      send_item(CMD_RUN, 6'd0, 6'd0, 0);
      wait_idle();
      set_config(4, 50, 0, 1, 2, 24'hFFFFFF);
      send_item(CMD_RUN, 6'd0, 6'd0, 0);
      wait_idle();
      set_config(4, 30, 40000, 1, 63, 1000);
      send_item(CMD_RUN, 6'd0, 6'd0, 0);
      wait_idle();
      set_config(0, 5, 55706, 0, 0, 16777);
      send_item(CMD_RUN, 6'd0, 6'd0, 0);
      send_item(CMD_CLEAR, 6'd0, 6'd0, 0);
      wait_idle();
      set_config(127, 1, 55706, 0, 0, 16777);
      send_item(CMD_ADD_EDGE, 6'd62, 6'd63, 0);
      send_item(CMD_ADD_EDGE, 6'd0, 6'd63, 0);
      send_item(CMD_RUN, 6'd0, 6'd0, 0);
      wait_idle();

      // output held off while runs keep arriving, so the input backs up
      set_config(3, 3, 50000, 0, 0, 100);
      hold_request = 1'b1;
      for (int i = 0; i < 8; i++) send_item(CMD_RUN, 6'($urandom), 6'($urandom), 0);
      wait_idle();

      random_phase(30, 1);
      for (int p = 0; p < 12; p++) random_phase($urandom_range(20, 35), 0);
      random_phase(20, 1);

      wait_idle();
      if (ranks.errors == 0 && ranks.pending_ranks.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/prpi_pkg.sv
rtl/prpi_div.sv
rtl/prpi_datapath.sv
rtl/prpi_ctrl.sv
rtl/pagerank_power_iteration.sv
bench/pagerank_power_iteration_tb.sv
